@@ rtl/lpr_pkg.sv @@
package lpr_pkg;

	localparam int unsigned ENTRIES_DEF = 64;

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_INSERT = 1'b1;

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_MISS     = 2'd1,
		ST_INSERTED = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic        mode;
		logic [31:0] route_dest;
		logic [31:0] route_mask;
		logic [31:0] route_gateway;
		logic [3:0]  route_port;
		logic [31:0] lookup_addr;
	} request_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] next_hop;
		logic [3:0]  out_port;
	} response_t;

	// One stored route, as held in a cell.
	typedef struct packed {
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [3:0]  port;
	} route_t;

	// Lookup token: the address and the best match found so far.
	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] best_mask;
		logic [31:0] best_gw;
		logic [3:0]  best_port;
	} token_t;

endpackage

@@ rtl/lpr_cell.sv @@
module lpr_cell
	import lpr_pkg::*;
#(
	parameter int unsigned LEFT_W = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  route_t            wr_route,
	input  logic              tok_vld_in,
	input  token_t            tok_in,
	input  logic [LEFT_W-1:0] left_in,
	output logic              tok_vld_out,
	output token_t            tok_out,
	output logic [LEFT_W-1:0] left_out
);

	route_t            route_q;
	logic              tok_vld_q;
	token_t            tok_q;
	logic [LEFT_W-1:0] left_q;

	logic   live;
	logic   hit;
	token_t tok_next;

	// The cell only takes part while the token still has stored routes to visit.
	assign live = (left_in != '0);
	assign hit  = live
		&& ((tok_in.addr & route_q.mask) == (route_q.dest & route_q.mask))
		&& (route_q.mask > tok_in.best_mask);

	always_comb begin
		tok_next = tok_in;
		if (hit) begin
			tok_next.best_mask = route_q.mask;
			tok_next.best_gw   = route_q.gateway;
			tok_next.best_port = route_q.port;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			route_q <= wr_route;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_vld_in;
		end
	end

	always_ff @(posedge clk) begin
		tok_q  <= tok_next;
		left_q <= live ? left_in - LEFT_W'(1) : left_in;
	end

	assign tok_vld_out = tok_vld_q;
	assign tok_out     = tok_q;
	assign left_out    = left_q;

endmodule

@@ rtl/longest_prefix_route_lookup_top.sv @@
// IPv4 longest-prefix route table built as a row of ENTRIES cells, each cell
// holding one route. An insert is written straight into the next free cell and
// its result (inserted, or table full) appears in the cycle after the item is
// taken; busy stays low for inserts. A lookup launches a token into the first
// cell carrying the address and a count of stored routes; the token moves one
// cell per clock, and each cell replaces the running best when its masked
// destination matches and its mask is strictly larger, so the earlier route
// wins on equal masks and an all-zero mask never wins. A lookup's result is
// registered once the token has passed the register of every cell in the row,
// and busy is high while the token walks the row, dropping as it is shown.
// A new item may be started in the very cycle its predecessor's result is shown.
// Every result is presented for exactly one cycle with done high; the receiver
// cannot stall the block, so it must capture the response whenever done is set.
module longest_prefix_route_lookup_top
	import lpr_pkg::*;
#(
	parameter int unsigned ENTRIES = ENTRIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  request_t  request,
	output logic      done,
	output response_t response
);

	localparam int unsigned CW = $clog2(ENTRIES + 1);

	logic [CW-1:0] count_q;
	logic          busy_q;
	logic          done_q;
	response_t     response_q;

	logic   accept;
	logic   ins_fire;
	logic   look_fire;
	logic   full;
	route_t wr_route;

	// Token chain: index 0 is the launch point, index ENTRIES the end of the row.
	logic          tok_vld [0:ENTRIES];
	token_t        tok     [0:ENTRIES];
	logic [CW-1:0] left    [0:ENTRIES];

	response_t look_rsp;
	response_t ins_rsp;

	assign accept    = start && !busy_q;
	assign ins_fire  = accept && (request.mode == MODE_INSERT);
	assign look_fire = accept && (request.mode == MODE_LOOKUP);
	assign full      = (count_q == CW'(ENTRIES));

	assign wr_route.dest    = request.route_dest;
	assign wr_route.mask    = request.route_mask;
	assign wr_route.gateway = request.route_gateway;
	assign wr_route.port    = request.route_port;

	// The token starts with no match and visits only the routes stored so far.
	assign tok_vld[0]        = look_fire;
	assign tok[0].addr       = request.lookup_addr;
	assign tok[0].best_mask  = '0;
	assign tok[0].best_gw    = '0;
	assign tok[0].best_port  = '0;
	assign left[0]           = count_q;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic wr_sel;

		// A full table never matches any cell index, so a refused insert writes nothing.
		assign wr_sel = ins_fire && (count_q == CW'(i));

		lpr_cell #(
			.LEFT_W(CW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.wr_en      (wr_sel),
			.wr_route   (wr_route),
			.tok_vld_in (tok_vld[i]),
			.tok_in     (tok[i]),
			.left_in    (left[i]),
			.tok_vld_out(tok_vld[i+1]),
			.tok_out    (tok[i+1]),
			.left_out   (left[i+1])
		);
	end

	// Final answer from the token leaving the last cell.
	always_comb begin
		look_rsp.status   = ST_MISS;
		look_rsp.next_hop = '0;
		look_rsp.out_port = '0;
		if (tok[ENTRIES].best_mask != '0) begin
			look_rsp.status   = ST_HIT;
			look_rsp.next_hop = (tok[ENTRIES].best_gw != '0) ? tok[ENTRIES].best_gw
				: tok[ENTRIES].addr;
			look_rsp.out_port = tok[ENTRIES].best_port;
		end
	end

	always_comb begin
		ins_rsp.status   = full ? ST_FULL : ST_INSERTED;
		ins_rsp.next_hop = '0;
		ins_rsp.out_port = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (ins_fire && !full) begin
				count_q <= count_q + CW'(1);
			end
			if (look_fire) begin
				busy_q <= 1'b1;
			end else if (tok_vld[ENTRIES]) begin
				busy_q <= 1'b0;
			end
			done_q <= ins_fire || tok_vld[ENTRIES];
		end
	end

	// An insert and a finishing lookup never meet: inserts are refused while busy.
	always_ff @(posedge clk) begin
		response_q <= ins_fire ? ins_rsp : look_rsp;
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign response = response_q;

endmodule

@@ rtl/lpr_checker.sv @@
module lpr_checker
	import lpr_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input request_t  request,
	input logic      done,
	input response_t response
);

	// A result never appears while a lookup is still walking the row.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// A lookup that is taken holds the block busy.
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.mode == MODE_LOOKUP) |=> busy)
		else $error("lookup taken without busy");

	// An insert answers in the next cycle with an insert status.
	a_insert_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.mode == MODE_INSERT) |=>
		(done && (response.status == ST_INSERTED || response.status == ST_FULL)))
		else $error("insert result missing or wrong");

	// The end of a lookup always comes with its result.
	a_end_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("lookup ended without a result");

	// Only a hit carries a next hop and a port.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && response.status != ST_HIT) |->
		(response.next_hop == '0 && response.out_port == '0))
		else $error("non-hit result carries data");

endmodule

bind longest_prefix_route_lookup_top lpr_checker u_lpr_checker (.*);

@@ verif/tb_longest_prefix_route_lookup_top.sv @@
`timescale 1ns / 100ps

module tb_longest_prefix_route_lookup_top
	import lpr_pkg::*;
;

	localparam int unsigned RANDOM_ITEMS   = 400;
	// The final stretch of random items runs without any sender gaps.
	localparam int unsigned CALM_TAIL      = 50;
	// A lookup walks the whole cell row, so the block can stay quiet for
	// the length of that walk plus the longest sender gap. This limit is
	// many times that.
	localparam int unsigned WATCHDOG_LIMIT = 1000;

	// Mirror of the route table. Every accepted request is applied to the
	// mirror, and the response the block should give is queued in order.
	// Responses come back in request order because a lookup holds busy
	// until its result is shown.
	class route_table_mirror;
		logic [31:0] dest_tab [ENTRIES_DEF];
		logic [31:0] mask_tab [ENTRIES_DEF];
		logic [31:0] gw_tab [ENTRIES_DEF];
		logic [3:0] port_tab [ENTRIES_DEF];
		int unsigned route_count;
		response_t awaited_responses[$];
		int unsigned mismatch_count;
		int unsigned hit_count;
		int unsigned miss_count;
		int unsigned insert_count;
		int unsigned full_count;

		function new();
			route_count = 0;
			mismatch_count = 0;
			hit_count = 0;
			miss_count = 0;
			insert_count = 0;
			full_count = 0;
		endfunction

		// Applies one request to the mirror and returns the response it causes.
		function response_t resolve_route(request_t req);
			response_t rsp;
			logic [31:0] best_mask;
			int unsigned best_idx;
			rsp.status = ST_MISS;
			rsp.next_hop = '0;
			rsp.out_port = '0;
			if (req.mode == MODE_INSERT) begin
				if (route_count < ENTRIES_DEF) begin
					dest_tab[route_count] = req.route_dest;
					mask_tab[route_count] = req.route_mask;
					gw_tab[route_count] = req.route_gateway;
					port_tab[route_count] = req.route_port;
					route_count++;
					rsp.status = ST_INSERTED;
				end else begin
					rsp.status = ST_FULL;
				end
			end else begin
				best_mask = '0;
				best_idx = 0;
				// Strictly larger mask wins, so the earlier route keeps ties and
				// an all-zero mask can never win.
				for (int unsigned i = 0; i < route_count; i++) begin
					if (((req.lookup_addr & mask_tab[i]) == (dest_tab[i] & mask_tab[i]))
							&& (mask_tab[i] > best_mask)) begin
						best_mask = mask_tab[i];
						best_idx = i;
					end
				end
				if (best_mask != '0) begin
					rsp.status = ST_HIT;
					rsp.next_hop = (gw_tab[best_idx] != '0) ? gw_tab[best_idx]
						: req.lookup_addr;
					rsp.out_port = port_tab[best_idx];
				end
			end
			return rsp;
		endfunction

		function void note_request(request_t req);
			response_t rsp;
			rsp = resolve_route(req);
			case (rsp.status)
				ST_HIT: hit_count++;
				ST_MISS: miss_count++;
				ST_INSERTED: insert_count++;
				default: full_count++;
			endcase
			awaited_responses = {awaited_responses, rsp};
		endfunction

		function void check_response(response_t got);
			response_t want;
			if (awaited_responses.size() == 0) begin
				$error("response with nothing awaited: status %0d next_hop %h out_port %0d",
					got.status, got.next_hop, got.out_port);
				mismatch_count++;
				return;
			end
			want = awaited_responses.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				mismatch_count++;
			end
			if (got.next_hop !== want.next_hop) begin
				$error("next_hop: expected %h, actual %h", want.next_hop, got.next_hop);
				mismatch_count++;
			end
			if (got.out_port !== want.out_port) begin
				$error("out_port: expected %0d, actual %0d", want.out_port, got.out_port);
				mismatch_count++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	request_t request = '0;
	logic done;
	response_t response;

	route_table_mirror mirror;
	int unsigned stall_cycles = 0;

	longest_prefix_route_lookup_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.response(response)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Every response is taken at the edge that ends its cycle. The values
	// seen here are the ones from before the edge, since the block updates
	// its outputs with nonblocking assignments.
	always @(posedge clk) begin
		if (arst_n && done) begin
			mirror.check_response(response);
		end
	end

	// The watchdog restarts whenever a request or a response crosses the
	// interface, so only a real hang can trip it.
	always @(posedge clk) begin
		if ((arst_n && start && !busy) || (arst_n && done)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL longest_prefix_route_lookup_top");
			$finish;
		end
	end

	function automatic request_t make_req(logic mode, logic [31:0] dest, logic [31:0] mask,
			logic [31:0] gw, logic [3:0] port, logic [31:0] addr);
		request_t req;
		req.mode = mode;
		req.route_dest = dest;
		req.route_mask = mask;
		req.route_gateway = gw;
		req.route_port = port;
		req.lookup_addr = addr;
		return req;
	endfunction

	function automatic logic [31:0] prefix_mask(int unsigned len);
		if (len == 0) begin
			return '0;
		end
		return 32'hFFFF_FFFF << (32 - len);
	endfunction

	// Inserts mostly carry contiguous prefixes. Half of them reuse the network
	// of a stored route so that prefixes nest and overlap, which is where the
	// longest-match choice actually matters. A few carry a zero mask or a
	// scattered mask. The lookup field is random noise.
	function automatic request_t random_insert();
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] gw;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			mask = $urandom;
		end else if (pick == 1) begin
			mask = '0;
		end else begin
			mask = prefix_mask($urandom_range(1, 32));
		end
		if (mirror.route_count > 0 && $urandom_range(0, 1) == 1) begin
			dest = mirror.dest_tab[$urandom_range(0, mirror.route_count - 1)] ^ ($urandom
				& ~mask);
		end else begin
			dest = $urandom;
		end
		gw = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
		return make_req(MODE_INSERT, dest, mask, gw, 4'($urandom_range(0, 15)), $urandom);
	endfunction

	// Most lookups aim at a stored route with random host bits; some of those
	// have one bit flipped so they fall to a shorter prefix or miss. The rest
	// are plain random addresses. Route fields are random noise.
	function automatic request_t random_lookup();
		logic [31:0] addr;
		int unsigned idx;
		if (mirror.route_count > 0 && $urandom_range(0, 9) < 8) begin
			idx = $urandom_range(0, mirror.route_count - 1);
			addr = (mirror.dest_tab[idx] & mirror.mask_tab[idx]) | ($urandom
				& ~mirror.mask_tab[idx]);
			if ($urandom_range(0, 5) == 0) begin
				addr[$urandom_range(0, 31)] ^= 1'b1;
			end
		end else begin
			addr = $urandom;
		end
		return make_req(MODE_LOOKUP, $urandom, $urandom, $urandom, 4'($urandom_range(0, 15)),
			addr);
	endfunction

	// Presents one item after an optional gap and returns at the edge where
	// it was taken. Start is left high there, so a back-to-back item only
	// changes the request and never drops start within the same step.
	task automatic send_item(request_t item, int unsigned gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= item;
		do begin
			@(posedge clk);
		end while (busy);
		mirror.note_request(item);
	endtask

	function automatic int unsigned pick_gap(bit calm);
		if (calm || $urandom_range(0, 9) >= 3) begin
			return 0;
		end
		return $urandom_range(1, 14);
	endfunction

	initial begin
		request_t directed [$];
		request_t item;
		mirror = new();

		// Empty table, then a default route that must never produce a hit.
		directed = {directed, make_req(MODE_LOOKUP, '0, '0, '0, '0, 32'hFFFF_FFFF)};
		directed = {directed, make_req(MODE_INSERT, 32'h0, 32'h0, 32'h0A00_0001, 4'd1,
			'0)};
		directed = {directed, make_req(MODE_LOOKUP, '0, '0, '0, '0, 32'h0102_0304)};
		// Nested prefixes: /8 through a gateway, /16 directly attached, two /24
		// with equal masks where the first must win (the first one also carries
		// host bits in its destination), and a /32 host route.
		directed = {directed, make_req(MODE_INSERT, 32'h0A00_0000, prefix_mask(8),
			32'h0A00_00FE, 4'd2, '0)};
		directed = {directed, make_req(MODE_INSERT, 32'h0A01_0000, prefix_mask(16), 32'h0,
			4'd3, '0)};
		directed = {directed, make_req(MODE_INSERT, 32'h0A01_024D, prefix_mask(24),
			32'hFFFF_FFFF, 4'd15, '0)};
		directed = {directed, make_req(MODE_INSERT, 32'h0A01_0200, prefix_mask(24),
			32'hC0A8_0001, 4'd4, '0)};
		directed = {directed, make_req(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1,
			4'd0, '0)};
		// A scattered mask, used bit for bit.
		directed = {directed, make_req(MODE_INSERT, 32'h00FF_00FF, 32'h00FF_00FF,
			32'h1234_5678, 4'd9, '0)};
		directed = {directed, make_req(MODE_LOOKUP, '0, '0, '0, '0, 32'h0A01_02C8)};
		directed = {directed, make_req(MODE_LOOKUP, '0, '0, '0, '0, 32'h0A01_0304)};
		directed = {directed, make_req(MODE_LOOKUP, '0, '0, '0, '0, 32'h0AC8_0001)};
		directed = {directed, make_req(MODE_LOOKUP, '0, '0, '0, '0, 32'h0B00_0000)};
		directed = {directed, make_req(MODE_LOOKUP, '0, '0, '0, '0, 32'hFFFF_FFFF)};
		directed = {directed, make_req(MODE_LOOKUP, '0, '0, '0, '0, 32'h55FF_66FF)};
		// Matches both the /8 and the scattered mask; the larger mask wins.
		directed = {directed, make_req(MODE_LOOKUP, '0, '0, '0, '0, 32'h0AFF_00FF)};
		directed = {directed, make_req(MODE_LOOKUP, '0, '0, '0, '0, 32'h0000_0000)};
		// Lookup with every route field at its maximum, all of it ignored.
		directed = {directed, make_req(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 4'd15, 32'h0A01_0203)};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_item(directed[i], pick_gap(1'b0));
		end

		// About a third of the random items are inserts, so the table fills
		// part way through and the later inserts are refused as full.
		for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
			item = ($urandom_range(0, 99) < 30) ? random_insert() : random_lookup();
			send_item(item, pick_gap(i >= RANDOM_ITEMS - CALM_TAIL));
		end
		start <= 1'b0;

		while (mirror.awaited_responses.size() != 0) begin
			@(posedge clk);
		end
		repeat (ENTRIES_DEF + 4) @(posedge clk);

		$display("Run covered %0d items: %0d inserts, %0d refused on a full table,",
			directed.size() + RANDOM_ITEMS, mirror.insert_count, mirror.full_count);
		$display("%0d lookup hits and %0d lookup misses.", mirror.hit_count,
			mirror.miss_count);
		if (mirror.mismatch_count == 0 && mirror.awaited_responses.size() == 0) begin
			$display("PASS longest_prefix_route_lookup_top");
		end else begin
			$display("FAIL longest_prefix_route_lookup_top");
		end
		$finish;
	end

endmodule

@@ longest_prefix_route_lookup_top.f @@
rtl/lpr_pkg.sv
rtl/lpr_cell.sv
rtl/longest_prefix_route_lookup_top.sv
rtl/lpr_checker.sv
verif/tb_longest_prefix_route_lookup_top.sv
